// ===== src/uadsc_pkg.sv =====
// Package for the audio stream descriptor scanner.
// Holds descriptor codes, the front-to-back event type and the result type.
// Depends on nothing; every other source file but uadsc_fifo imports it.
`default_nettype none

package uadsc_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_WANTED_RATE     = 2'd0,
    REG_WANTED_CHANNELS = 2'd1,
    REG_WANTED_SUBFRAME = 2'd2,
    REG_WANTED_BITS     = 2'd3
  } cfg_reg_e;

  // Reset values of the configuration registers
  localparam logic [23:0] RATE_RESET     = 24'd48000;
  localparam logic [7:0]  CHANNELS_RESET = 8'd1;
  localparam logic [7:0]  SUBFRAME_RESET = 8'd2;
  localparam logic [7:0]  BITS_RESET     = 8'd16;

  // Descriptor types and subtypes
  localparam logic [7:0] KIND_INTERFACE    = 8'h04;
  localparam logic [7:0] KIND_CS_INTERFACE = 8'h24;
  localparam logic [7:0] KIND_ENDPOINT     = 8'h05;
  localparam logic [7:0] CLASS_AUDIO       = 8'd1;
  localparam logic [7:0] SUBCLASS_STREAM   = 8'd2;
  localparam logic [7:0] SUBTYPE_FORMAT    = 8'd2;
  localparam logic [7:0] FORMAT_TYPE_I     = 8'd1;
  localparam logic [1:0] XFER_ISO          = 2'b01;

  // Minimum lengths and byte positions
  localparam logic [7:0] LEN_MIN       = 8'd2;
  localparam logic [7:0] LEN_INTERFACE = 8'd9;
  localparam logic [7:0] LEN_FORMAT    = 8'd8;
  localparam logic [7:0] LEN_ENDPOINT  = 8'd7;
  localparam logic [7:0] LEN_RANGE     = 8'd14;
  localparam logic [7:0] POS_KIND      = 8'd1;
  localparam logic [7:0] POS_HDR_FIRST = 8'd2;
  localparam logic [7:0] POS_HDR_LAST  = 8'd7;
  localparam logic [7:0] POS_RATE      = 8'd8;

  // Wanted stream format
  typedef struct packed {
    logic [23:0] rate;
    logic [7:0]  channels;
    logic [7:0]  subframe;
    logic [7:0]  bits;
  } cfg_t;

  // One completed descriptor and/or end of the descriptor set
  typedef struct packed {
    logic            last;
    logic            done;
    logic [7:0]      kind;
    logic [7:0]      len;
    logic [7:2][7:0] hdr;
    logic            fmt_ok;
  } ev_t;

  // One scan result
  typedef struct packed {
    logic        found;
    logic [7:0]  iface_num;
    logic [7:0]  alt_setting;
    logic [7:0]  endpoint_address;
    logic [10:0] max_pkt_size;
  } res_t;

endpackage

`default_nettype wire

// ===== src/usb_audio_stream_descriptor_scan.sv =====
// Top level of the audio stream descriptor scanner: config registers, front, back, queues.
// Depends on uadsc_pkg, uadsc_fifo, uadsc_front and uadsc_back.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------------------
//  input    | push / full                | data_byte_i, last_byte_i
//  result   | empty / pop                | found_o, iface_num_o, alt_setting_o,
//           |                            | endpoint_address_o, max_pkt_size_o
//  config   | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One byte is accepted per cycle while full is low; the front end forms its event from it
// combinationally. A completed descriptor or end of set goes through a two-entry event
// queue to the back end, which applies one event per cycle unless stalled as below, and
// the result goes through the result queue to the result ports. full rises only while
// the event queue holds two events; a stalled result queue stalls the back end at the next
// end-of-set event. Reset clears all parse state but the header bytes at once.
`default_nettype none

module usb_audio_stream_descriptor_scan
  import uadsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic        found_o,
  output logic [7:0]  iface_num_o,
  output logic [7:0]  alt_setting_o,
  output logic [7:0]  endpoint_address_o,
  output logic [10:0] max_pkt_size_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  cfg_t cfg_q;
  logic accept;
  logic ev_push, ev_pop, ev_full, ev_empty;
  ev_t  ev_in, ev_out;
  logic res_push, res_full;
  res_t res_in, res_out;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;
  assign full        = ev_full;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rate     <= RATE_RESET;
      cfg_q.channels <= CHANNELS_RESET;
      cfg_q.subframe <= SUBFRAME_RESET;
      cfg_q.bits     <= BITS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_WANTED_RATE:     cfg_q.rate     <= cfg_data_i;
        REG_WANTED_CHANNELS: cfg_q.channels <= cfg_data_i[7:0];
        REG_WANTED_SUBFRAME: cfg_q.subframe <= cfg_data_i[7:0];
        REG_WANTED_BITS:     cfg_q.bits     <= cfg_data_i[7:0];
        default:             cfg_q          <= cfg_q;
      endcase
    end
  end

  uadsc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .data_byte_i(data_byte_i),
    .last_byte_i(last_byte_i),
    .cfg_i      (cfg_q),
    .ev_push_o  (ev_push),
    .ev_o       (ev_in)
  );

  uadsc_fifo #(
    .Width($bits(ev_t))
  ) u_ev_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (ev_push),
    .data_i (ev_in),
    .full_o (ev_full),
    .pop_i  (ev_pop),
    .data_o (ev_out),
    .empty_o(ev_empty)
  );

  uadsc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .ev_valid_i(!ev_empty),
    .ev_i      (ev_out),
    .ev_pop_o  (ev_pop),
    .res_full_i(res_full),
    .res_push_o(res_push),
    .res_o     (res_in)
  );

  uadsc_fifo #(
    .Width($bits(res_t))
  ) u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_in),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (res_out),
    .empty_o(empty)
  );

  assign found_o            = res_out.found;
  assign iface_num_o        = res_out.iface_num;
  assign alt_setting_o      = res_out.alt_setting;
  assign endpoint_address_o = res_out.endpoint_address;
  assign max_pkt_size_o     = res_out.max_pkt_size;

endmodule

`default_nettype wire

// ===== src/uadsc_fifo.sv =====
// Two-entry queue used between front and back and in front of the result port.
// Stand-alone; width set by the instantiating module.
`default_nettype none

module uadsc_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned Depth = 2;

  logic [Width-1:0] mem_q [Depth];
  logic             wr_q, wr_d;
  logic             rd_q, rd_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'(Depth));
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // Advance pointers and count
  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Store pushed item
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(Depth))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

// ===== src/uadsc_front.sv =====
// Byte front end: tracks descriptor boundaries, keeps header bytes and checks the rate list.
// Emits one event per completed descriptor or end of set. Uses uadsc_pkg.
`default_nettype none

module uadsc_front
  import uadsc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  cfg_t       cfg_i,
  output logic       ev_push_o,
  output ev_t        ev_o
);

  // Byte within one three-byte rate entry
  typedef enum logic [1:0] {
    RB_LO  = 2'd0,
    RB_MID = 2'd1,
    RB_HI  = 2'd2
  } rate_byte_e;

  logic [7:0]      len_q, len_d;
  logic [7:0]      pos_q, pos_d;
  logic [7:0]      kind_q, kind_d;
  logic [15:0]     rate_lo_q, rate_lo_d;
  logic            listed_q, listed_d;
  rate_byte_e      rb_q, rb_d;
  logic [6:0]      grp_q, grp_d;
  logic            stopped_q, stopped_d;
  logic [7:2][7:0] hdr_q, hdr_n;

  logic        take;
  logic        hdr_wr;
  logic        complete;
  logic [7:0]  pos_inc;
  logic [7:0]  count;
  logic [23:0] rate_full;
  logic [9:0]  need_len;

  assign take    = accept_i && !stopped_q;
  assign hdr_wr  = take && (pos_q >= POS_HDR_FIRST) && (pos_q <= POS_HDR_LAST);
  assign pos_inc = pos_q + 8'd1;
  assign count   = hdr_n[7];
  assign rate_full = {data_byte_i, rate_lo_q};
  assign need_len  = 10'd8 + {1'b0, count, 1'b0} + {2'b0, count};

  // Merge the current byte into the header
  always_comb begin
    hdr_n = hdr_q;
    for (int i = 2; i <= 7; i++) begin
      if (hdr_wr && (pos_q[2:0] == 3'(i))) begin
        hdr_n[i] = data_byte_i;
      end
    end
  end

  // Walk the descriptor set one byte at a time
  always_comb begin
    len_d     = len_q;
    pos_d     = pos_q;
    kind_d    = kind_q;
    rate_lo_d = rate_lo_q;
    listed_d  = listed_q;
    rb_d      = rb_q;
    grp_d     = grp_q;
    stopped_d = stopped_q;
    complete  = 1'b0;
    if (take) begin
      if (pos_q == 8'd0) begin
        len_d = data_byte_i;
        if (data_byte_i < LEN_MIN) begin
          stopped_d = 1'b1;
        end else begin
          kind_d    = 8'd0;
          rate_lo_d = 16'd0;
          listed_d  = 1'b0;
          rb_d      = RB_LO;
          grp_d     = 7'd0;
          pos_d     = 8'd1;
        end
      end else begin
        if (pos_q == POS_KIND) begin
          kind_d = data_byte_i;
        end
        // Assemble rate entries and check them against the wanted rate
        if (pos_q >= POS_RATE) begin
          unique case (rb_q)
            RB_LO: begin
              rate_lo_d = {8'd0, data_byte_i};
              rb_d      = RB_MID;
            end
            RB_MID: begin
              rate_lo_d[15:8] = data_byte_i;
              rb_d            = RB_HI;
            end
            RB_HI: begin
              rb_d  = RB_LO;
              grp_d = grp_q + 7'd1;
              if (hdr_q[7] == 8'd0) begin
                if (grp_q == 7'd0) begin
                  listed_d = (cfg_i.rate >= rate_full);
                end else if (grp_q == 7'd1) begin
                  listed_d = listed_q && (cfg_i.rate <= rate_full);
                end
              end else if (({1'b0, grp_q} < hdr_q[7]) && (rate_full == cfg_i.rate)) begin
                listed_d = 1'b1;
              end
            end
            default: begin
              rb_d = RB_LO;
            end
          endcase
        end
        if (pos_inc == len_q) begin
          pos_d    = 8'd0;
          complete = 1'b1;
        end else begin
          pos_d = pos_inc;
        end
      end
    end
  end

  // Build the event for the back end
  always_comb begin
    ev_o.last = last_byte_i;
    ev_o.done = complete;
    ev_o.kind = kind_d;
    ev_o.len  = len_q;
    ev_o.hdr  = hdr_n;
    if (count == 8'd0) begin
      ev_o.fmt_ok = (len_q >= LEN_RANGE) && listed_d;
    end else begin
      ev_o.fmt_ok = ({2'b0, len_q} >= need_len) && listed_d;
    end
  end

  assign ev_push_o = accept_i && (complete || last_byte_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= 8'd0;
      pos_q     <= 8'd0;
      kind_q    <= 8'd0;
      rate_lo_q <= 16'd0;
      listed_q  <= 1'b0;
      rb_q      <= RB_LO;
      grp_q     <= 7'd0;
      stopped_q <= 1'b0;
    end else if (accept_i && last_byte_i) begin
      // Drop all parse state but the header bytes at the end of the set
      len_q     <= 8'd0;
      pos_q     <= 8'd0;
      kind_q    <= 8'd0;
      rate_lo_q <= 16'd0;
      listed_q  <= 1'b0;
      rb_q      <= RB_LO;
      grp_q     <= 7'd0;
      stopped_q <= 1'b0;
    end else begin
      len_q     <= len_d;
      pos_q     <= pos_d;
      kind_q    <= kind_d;
      rate_lo_q <= rate_lo_d;
      listed_q  <= listed_d;
      rb_q      <= rb_d;
      grp_q     <= grp_d;
      stopped_q <= stopped_d;
    end
  end

  // Hold header bytes
  always_ff @(posedge clk_i) begin
    hdr_q <= hdr_n;
  end

  a_stop_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |-> (pos_q == 8'd0))
    else $error("parsing stopped inside a descriptor");

  a_pos_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q != 8'd0) |-> (pos_q < len_q))
    else $error("byte position past descriptor length");

endmodule

`default_nettype wire

// ===== src/uadsc_back.sv =====
// Back end: applies completed descriptors to the candidate stream and forms results.
// Consumes front events, produces res_t items. Uses uadsc_pkg.
`default_nettype none

module uadsc_back
  import uadsc_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic ev_valid_i,
  input  ev_t  ev_i,
  output logic ev_pop_o,
  input  logic res_full_i,
  output logic res_push_o,
  output res_t res_o
);

  logic        stream_q, stream_d;
  logic [7:0]  cif_q, cif_d;
  logic [7:0]  calt_q, calt_d;
  logic [7:0]  cep_q, cep_d;
  logic [10:0] cmps_q, cmps_d;
  logic [7:0]  cch_q, cch_d;
  logic [7:0]  csub_q, csub_d;
  logic [7:0]  cbits_q, cbits_d;
  logic        cok_q, cok_d;
  logic        latched_q, latched_d;
  logic        hit;

  function automatic logic cand_match(logic [7:0] ep, logic ok, logic [7:0] ch,
                                      logic [7:0] sub, logic [7:0] bits, cfg_t cfg);
    return (ep != 8'd0) && ok && (ch == cfg.channels) && (sub == cfg.subframe) &&
           (bits == cfg.bits);
  endfunction

  // Take an event once a result, if any, has room
  assign ev_pop_o   = ev_valid_i && (!ev_i.last || !res_full_i);
  assign res_push_o = ev_pop_o && ev_i.last;

  // Apply a completed descriptor
  always_comb begin
    stream_d  = stream_q;
    cif_d     = cif_q;
    calt_d    = calt_q;
    cep_d     = cep_q;
    cmps_d    = cmps_q;
    cch_d     = cch_q;
    csub_d    = csub_q;
    cbits_d   = cbits_q;
    cok_d     = cok_q;
    latched_d = latched_q;
    if (ev_pop_o && ev_i.done && !latched_q) begin
      priority if ((ev_i.kind == KIND_INTERFACE) && (ev_i.len >= LEN_INTERFACE)) begin
        if (cand_match(cep_q, cok_q, cch_q, csub_q, cbits_q, cfg_i)) begin
          latched_d = 1'b1;
        end else begin
          cif_d    = ev_i.hdr[2];
          calt_d   = ev_i.hdr[3];
          stream_d = (ev_i.hdr[5] == CLASS_AUDIO) && (ev_i.hdr[6] == SUBCLASS_STREAM) &&
                     (ev_i.hdr[3] != 8'd0);
          cep_d    = 8'd0;
          cmps_d   = 11'd0;
          cch_d    = 8'd0;
          csub_d   = 8'd0;
          cbits_d  = 8'd0;
          cok_d    = 1'b0;
        end
      end else if (stream_q && (ev_i.kind == KIND_CS_INTERFACE) &&
                   (ev_i.len >= LEN_FORMAT) && (ev_i.hdr[2] == SUBTYPE_FORMAT) &&
                   (ev_i.hdr[3] == FORMAT_TYPE_I)) begin
        cch_d   = ev_i.hdr[4];
        csub_d  = ev_i.hdr[5];
        cbits_d = ev_i.hdr[6];
        cok_d   = ev_i.fmt_ok;
      end else if (stream_q && (ev_i.kind == KIND_ENDPOINT) &&
                   (ev_i.len >= LEN_ENDPOINT)) begin
        if ((ev_i.hdr[3][1:0] == XFER_ISO) && ev_i.hdr[2][7]) begin
          cep_d  = ev_i.hdr[2];
          cmps_d = {ev_i.hdr[5][2:0], ev_i.hdr[4]};
        end
      end else begin
        // Leave the candidate alone for any other descriptor
        cok_d = cok_q;
      end
    end
  end

  // Form the result from the updated candidate
  always_comb begin
    hit = latched_d || cand_match(cep_d, cok_d, cch_d, csub_d, cbits_d, cfg_i);
    res_o.found            = hit;
    res_o.iface_num        = hit ? cif_d : 8'd0;
    res_o.alt_setting      = hit ? calt_d : 8'd0;
    res_o.endpoint_address = hit ? cep_d : 8'd0;
    res_o.max_pkt_size     = hit ? cmps_d : 11'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stream_q  <= 1'b0;
      cif_q     <= 8'd0;
      calt_q    <= 8'd0;
      cep_q     <= 8'd0;
      cmps_q    <= 11'd0;
      cch_q     <= 8'd0;
      csub_q    <= 8'd0;
      cbits_q   <= 8'd0;
      cok_q     <= 1'b0;
      latched_q <= 1'b0;
    end else if (res_push_o) begin
      // Clear the candidate at the end of the set
      stream_q  <= 1'b0;
      cif_q     <= 8'd0;
      calt_q    <= 8'd0;
      cep_q     <= 8'd0;
      cmps_q    <= 11'd0;
      cch_q     <= 8'd0;
      csub_q    <= 8'd0;
      cbits_q   <= 8'd0;
      cok_q     <= 1'b0;
      latched_q <= 1'b0;
    end else begin
      stream_q  <= stream_d;
      cif_q     <= cif_d;
      calt_q    <= calt_d;
      cep_q     <= cep_d;
      cmps_q    <= cmps_d;
      cch_q     <= cch_d;
      csub_q    <= csub_d;
      cbits_q   <= cbits_d;
      cok_q     <= cok_d;
      latched_q <= latched_d;
    end
  end

  a_latched_ep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    latched_q |-> (cep_q != 8'd0))
    else $error("match latched without an endpoint");

  a_set_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |=> (!latched_q && !stream_q && (cep_q == 8'd0)))
    else $error("candidate not cleared after end of set");

  a_latched_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push_o && latched_q) |-> res_o.found)
    else $error("latched match not reported");

endmodule

`default_nettype wire

// ===== sim/usb_audio_stream_descriptor_scan_tb.sv =====
// Self-checking testbench for the audio stream descriptor scanner.
// Predicts each scan result from the bytes sent and checks it; depends on
// uadsc_pkg and usb_audio_stream_descriptor_scan.
`default_nettype none

module usb_audio_stream_descriptor_scan_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import uadsc_pkg::*;

  localparam int HDR_N       = 12;
  localparam int RATE_GROUPS = 83;
  localparam int SETTLE      = 8;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  // Descriptor kinds used only as filler
  localparam logic [7:0] KIND_CONFIG      = 8'h02;
  localparam logic [7:0] KIND_CS_ENDPOINT = 8'h25;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  data_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic        found_o;
  logic [7:0]  iface_num_o;
  logic [7:0]  alt_setting_o;
  logic [7:0]  endpoint_address_o;
  logic [10:0] max_pkt_size_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = REG_WANTED_RATE;
  logic [23:0] cfg_data_i = '0;

  usb_audio_stream_descriptor_scan u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .push                (push),
    .full                (full),
    .data_byte_i         (data_byte_i),
    .last_byte_i         (last_byte_i),
    .empty               (empty),
    .pop                 (pop),
    .found_o             (found_o),
    .iface_num_o         (iface_num_o),
    .alt_setting_o       (alt_setting_o),
    .endpoint_address_o  (endpoint_address_o),
    .max_pkt_size_o      (max_pkt_size_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Scan predictor: wanted format, parse state and the results still owed
  // ---------------------------------------------------------------------------
  cfg_t        want;
  logic [7:0]  d_len, d_pos, d_kind;
  logic [7:0]  hdr [HDR_N];
  logic [23:0] rate_acc;
  logic        rate_ok_acc, in_stream, scan_stopped, match_held;
  logic [7:0]  cand_if, cand_alt, cand_ep;
  logic [10:0] cand_mps;
  logic [24:0] cand_fmt;
  res_t        expected_matches [$];

  // Run bookkeeping
  bit          idle_enabled = 1'b1;
  bit          hold_results = 1'b0;
  int          rx_stall = 0;
  int          quiet_cycles = 0;
  int          stalled_cycles = 0;
  int          fail_count = 0;
  int          bytes_sent = 0;
  int          sets_checked = 0;
  int          matches_seen = 0;
  int          cfg_phases = 0;

  // Stimulus scratch: bytes of the set being built, rates of a format descriptor
  logic [7:0]  set_bytes [$];
  logic [23:0] group_rate [RATE_GROUPS];

  function automatic void clear_scan();
    d_len = '0;
    d_pos = '0;
    d_kind = '0;
    foreach (hdr[i]) hdr[i] = '0;
    rate_acc = '0;
    rate_ok_acc = 1'b0;
    in_stream = 1'b0;
    cand_if = '0;
    cand_alt = '0;
    cand_ep = '0;
    cand_mps = '0;
    cand_fmt = '0;
    scan_stopped = 1'b0;
    match_held = 1'b0;
  endfunction

  function automatic logic cand_hits();
    return cand_ep != 0 && cand_fmt[24] &&
           cand_fmt[7:0] == want.channels &&
           cand_fmt[15:8] == want.subframe &&
           cand_fmt[23:16] == want.bits;
  endfunction

  // Assemble a 3-byte rate and test it against the wanted rate
  function automatic void follow_rate(int pos, logic [7:0] b);
    int rel, grp, k, count;
    rel = pos - int'(POS_RATE);
    grp = rel / 3;
    k = rel % 3;
    count = hdr[7];
    if (k == 0) begin
      rate_acc = {16'd0, b};
    end else if (k == 1) begin
      rate_acc = rate_acc | {8'd0, b, 8'd0};
    end else begin
      rate_acc = rate_acc | {b, 16'd0};
      if (count == 0) begin
        if (grp == 0) rate_ok_acc = want.rate >= rate_acc;
        else if (grp == 1) rate_ok_acc = rate_ok_acc & (want.rate <= rate_acc);
      end else if (grp < count && rate_acc == want.rate) begin
        rate_ok_acc = 1'b1;
      end
    end
  endfunction

  // Act on a descriptor whose last byte has arrived
  function automatic void complete_desc();
    int   len, count;
    logic ok;
    len = d_len;
    if (d_kind == KIND_INTERFACE && len >= LEN_INTERFACE) begin
      if (cand_hits()) begin
        match_held = 1'b1;
        scan_stopped = 1'b1;
        return;
      end
      cand_if = hdr[2];
      cand_alt = hdr[3];
      in_stream = hdr[5] == CLASS_AUDIO && hdr[6] == SUBCLASS_STREAM && cand_alt != 0;
      cand_ep = '0;
      cand_mps = '0;
      cand_fmt = '0;
    end else if (in_stream && d_kind == KIND_CS_INTERFACE && len >= LEN_FORMAT &&
                 hdr[2] == SUBTYPE_FORMAT && hdr[3] == FORMAT_TYPE_I) begin
      count = hdr[7];
      if (count == 0) ok = len >= LEN_RANGE && rate_ok_acc;
      else ok = len >= int'(LEN_FORMAT) + 3 * count && rate_ok_acc;
      cand_fmt = {ok, hdr[6], hdr[5], hdr[4]};
    end else if (in_stream && d_kind == KIND_ENDPOINT && len >= LEN_ENDPOINT) begin
      if (hdr[3][1:0] == XFER_ISO && hdr[2][7]) begin
        cand_ep = hdr[2];
        cand_mps = {hdr[5][2:0], hdr[4]};
      end
    end
  endfunction

  // Advance the prediction by one accepted byte; a last byte owes one result
  function automatic void scan_descriptor_byte(logic [7:0] b, logic is_last);
    res_t r;
    logic hit;
    if (!scan_stopped) begin
      if (d_pos == 0) begin
        d_len = b;
        if (b < LEN_MIN) begin
          scan_stopped = 1'b1;
        end else begin
          hdr[0] = b;
          d_kind = '0;
          rate_acc = '0;
          rate_ok_acc = 1'b0;
          d_pos = 8'd1;
        end
      end else begin
        if (d_pos < HDR_N) hdr[d_pos] = b;
        if (d_pos == POS_KIND) d_kind = b;
        if (d_pos >= POS_RATE) follow_rate(d_pos, b);
        d_pos = d_pos + 8'd1;
        if (d_pos == d_len) begin
          d_pos = '0;
          complete_desc();
        end
      end
    end
    if (is_last) begin
      hit = match_held || cand_hits();
      r.found = hit;
      r.iface_num = hit ? cand_if : 8'd0;
      r.alt_setting = hit ? cand_alt : 8'd0;
      r.endpoint_address = hit ? cand_ep : 8'd0;
      r.max_pkt_size = hit ? cand_mps : 11'd0;
      expected_matches.push_back(r);
      clear_scan();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Descriptor builders
  // ---------------------------------------------------------------------------
  function automatic void add_raw(int len, logic [7:0] kind);
    set_bytes.push_back(8'(len));
    set_bytes.push_back(kind);
    repeat (len - 2) set_bytes.push_back(8'($urandom));
  endfunction

  function automatic void add_interface(logic [7:0] num, logic [7:0] alt,
                                        logic [7:0] cls, logic [7:0] sub);
    set_bytes.push_back(LEN_INTERFACE);
    set_bytes.push_back(KIND_INTERFACE);
    set_bytes.push_back(num);
    set_bytes.push_back(alt);
    set_bytes.push_back(8'($urandom_range(0, 3)));
    set_bytes.push_back(cls);
    set_bytes.push_back(sub);
    set_bytes.push_back(8'($urandom));
    set_bytes.push_back(8'($urandom));
  endfunction

  // Rate bytes come from group_rate, three bytes per group, low byte first
  function automatic void add_format(int len, logic [7:0] sub, logic [7:0] ftype,
                                     logic [7:0] ch, logic [7:0] sf, logic [7:0] bits,
                                     logic [7:0] count);
    logic [7:0] b;
    for (int p = 0; p < len; p++) begin
      case (p)
        0:       b = 8'(len);
        1:       b = KIND_CS_INTERFACE;
        2:       b = sub;
        3:       b = ftype;
        4:       b = ch;
        5:       b = sf;
        6:       b = bits;
        7:       b = count;
        default: b = group_rate[(p - 8) / 3][8 * ((p - 8) % 3) +: 8];
      endcase
      set_bytes.push_back(b);
    end
  endfunction

  function automatic void add_endpoint(int len, logic [7:0] addr, logic [7:0] attr,
                                       logic [15:0] mps);
    logic [7:0] b;
    for (int p = 0; p < len; p++) begin
      case (p)
        0:       b = 8'(len);
        1:       b = KIND_ENDPOINT;
        2:       b = addr;
        3:       b = attr;
        4:       b = mps[7:0];
        5:       b = mps[15:8];
        default: b = 8'($urandom);
      endcase
      set_bytes.push_back(b);
    end
  endfunction

  function automatic logic [7:0] near(logic [7:0] v);
    return ($urandom_range(0, 4) == 0) ? 8'($urandom) : v;
  endfunction

  function automatic logic [23:0] rate_offset(logic [23:0] base, int delta);
    int r;
    r = int'(base) + delta;
    if (r < 0) r = 0;
    if (r > 24'hFFFFFF) r = 24'hFFFFFF;
    return 24'(r);
  endfunction

  // One alternate setting: interface, format and endpoint, mostly well formed
  function automatic void add_stream_alt();
    logic [7:0]  alt, cls, sub, ch, sf, bits, fsub, ftype, addr, attr, count;
    logic [23:0] w;
    int          len, mode, hit_idx;
    bit          ep_first;
    w = want.rate;
    alt = ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    cls = ($urandom_range(0, 7) == 0) ? 8'($urandom) : CLASS_AUDIO;
    sub = ($urandom_range(0, 7) == 0) ? 8'($urandom) : SUBCLASS_STREAM;
    add_interface(8'($urandom), alt, cls, sub);
    if ($urandom_range(0, 2) == 0) add_raw($urandom_range(2, 12), KIND_CS_INTERFACE);
    ep_first = $urandom_range(0, 3) == 0;
    // endpoint, sometimes ahead of the format
    addr = ($urandom_range(0, 5) == 0) ? 8'($urandom) : {1'b1, 7'($urandom)};
    attr = ($urandom_range(0, 5) == 0) ? 8'($urandom) : {6'($urandom), XFER_ISO};
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 10) :
          (($urandom_range(0, 3) == 0) ? 9 : int'(LEN_ENDPOINT));
    if (ep_first && $urandom_range(0, 9) != 0) add_endpoint(len, addr, attr, 16'($urandom));
    // format type I descriptor
    ch = near(want.channels);
    sf = near(want.subframe);
    bits = near(want.bits);
    fsub = ($urandom_range(0, 9) == 0) ? 8'($urandom) : SUBTYPE_FORMAT;
    ftype = ($urandom_range(0, 9) == 0) ? 8'($urandom) : FORMAT_TYPE_I;
    foreach (group_rate[g]) group_rate[g] = 24'($urandom);
    mode = $urandom_range(0, 9);
    if (mode < 4) begin
      // continuous range, bounds around the wanted rate
      count = 8'd0;
      if ($urandom_range(0, 4) != 0) begin
        group_rate[0] = rate_offset(w, int'($urandom_range(0, 4)) - 3);
        group_rate[1] = rate_offset(w, int'($urandom_range(0, 4)) - 1);
      end
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 20) : int'(LEN_RANGE);
    end else if (mode < 9) begin
      // discrete list, at most one entry set to the wanted rate, others near it or random
      count = 8'($urandom_range(1, 4));
      hit_idx = $urandom_range(0, count);
      for (int g = 0; g < count; g++) begin
        if (g == hit_idx) group_rate[g] = w;
        else if ($urandom_range(0, 1) == 0)
          group_rate[g] = rate_offset(w, ($urandom_range(0, 1) == 0) ? 1 : -1);
      end
      len = int'(LEN_FORMAT) + 3 * count;
      if ($urandom_range(0, 4) == 0) len = len + int'($urandom_range(0, 6)) - 3;
    end else begin
      // list count too large for any real length
      count = 8'($urandom_range(83, 255));
      group_rate[0] = w;
      len = $urandom_range(11, 48);
    end
    if ($urandom_range(0, 9) != 0) add_format(len, fsub, ftype, ch, sf, bits, count);
    if (!ep_first && $urandom_range(0, 9) != 0) add_endpoint(len < 7 ? 7 : 7 + (len & 1),
                                                             addr, attr, 16'($urandom));
    if ($urandom_range(0, 5) == 0) add_raw($urandom_range(2, 9), KIND_CS_ENDPOINT);
  endfunction

  // A whole descriptor set, with short lengths, cuts and noise mixed in
  function automatic void build_set();
    int n_alt, cut;
    set_bytes.delete();
    if ($urandom_range(0, 2) == 0) add_raw(LEN_INTERFACE, KIND_CONFIG);
    n_alt = $urandom_range(1, 3);
    for (int i = 0; i < n_alt; i++) begin
      if ($urandom_range(0, 7) == 0) add_raw($urandom_range(2, 10), 8'($urandom));
      add_stream_alt();
    end
    case ($urandom_range(0, 11))
      0: begin
        set_bytes.push_back(8'($urandom_range(0, 1)));
        add_stream_alt();
      end
      1: begin
        cut = $urandom_range(1, set_bytes.size() > 12 ? 12 : set_bytes.size() - 1);
        repeat (cut) void'(set_bytes.pop_back());
      end
      2: repeat ($urandom_range(1, 6)) set_bytes.push_back(8'($urandom));
      3: if ($urandom_range(0, 3) == 0) add_raw($urandom_range(60, 255), 8'($urandom));
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] value, input logic is_last);
    @(negedge clk_i);
    push <= 1'b1;
    data_byte_i <= value;
    last_byte_i <= is_last;
    do @(posedge clk_i); while (full);
    scan_descriptor_byte(value, is_last);
    bytes_sent++;
    // drop push for a random burst now and then
    if (idle_enabled && $urandom_range(0, 7) == 0) begin
      @(negedge clk_i);
      push <= 1'b0;
      repeat ($urandom_range(1, 12) - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_set();
    foreach (set_bytes[i]) send_byte(set_bytes[i], i == set_bytes.size() - 1);
  endtask

  // Wait until every owed result has come back and the block has settled
  task automatic drain();
    @(negedge clk_i);
    push <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [23:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_WANTED_RATE:     want.rate = value;
      REG_WANTED_CHANNELS: want.channels = value[7:0];
      REG_WANTED_SUBFRAME: want.subframe = value[7:0];
      REG_WANTED_BITS:     want.bits = value[7:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_wanted(input logic [23:0] rate, input logic [7:0] ch,
                            input logic [7:0] sf, input logic [7:0] bits);
    write_reg(REG_WANTED_RATE, rate);
    write_reg(REG_WANTED_CHANNELS, {16'd0, ch});
    write_reg(REG_WANTED_SUBFRAME, {16'd0, sf});
    write_reg(REG_WANTED_BITS, {16'd0, bits});
    cfg_phases++;
  endtask

  // Pop side: random stall bursts, plus a long hold during the backpressure test
  always @(negedge clk_i) begin
    if (rx_stall > 0) begin
      rx_stall--;
      pop <= 1'b0;
    end else if (idle_enabled && $urandom_range(0, 9) == 0) begin
      rx_stall = $urandom_range(1, 12) - 1;
      pop <= 1'b0;
    end else begin
      pop <= !hold_results;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker and watchdog
  // ---------------------------------------------------------------------------
  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("mismatch: %s", msg);
  endfunction

  always @(posedge clk_i) begin
    res_t seen;
    res_t hope;
    if (rst_ni && pop && !empty) begin
      seen.found = found_o;
      seen.iface_num = iface_num_o;
      seen.alt_setting = alt_setting_o;
      seen.endpoint_address = endpoint_address_o;
      seen.max_pkt_size = max_pkt_size_o;
      sets_checked++;
      if (expected_matches.size() == 0) begin
        note_failure($sformatf("result with none owed: found=%0d if=%0d alt=%0d ep=%02h mps=%0d",
                               seen.found, seen.iface_num, seen.alt_setting,
                               seen.endpoint_address, seen.max_pkt_size));
      end else begin
        hope = expected_matches.pop_front();
        if (seen.found !== hope.found ||
            seen.iface_num !== hope.iface_num ||
            seen.alt_setting !== hope.alt_setting ||
            seen.endpoint_address !== hope.endpoint_address ||
            seen.max_pkt_size !== hope.max_pkt_size) begin
          note_failure($sformatf({"set %0d: expected found=%0d if=%0d alt=%0d ep=%02h mps=%0d,",
                                  " got found=%0d if=%0d alt=%0d ep=%02h mps=%0d"},
                                 sets_checked, hope.found, hope.iface_num,
                                 hope.alt_setting, hope.endpoint_address,
                                 hope.max_pkt_size, seen.found, seen.iface_num,
                                 seen.alt_setting, seen.endpoint_address,
                                 seen.max_pkt_size));
        end
        if (hope.found) matches_seen++;
      end
    end
  end

  // End the run if no handshake completes for too long
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) quiet_cycles = 0;
    else quiet_cycles++;
    if (push && full) stalled_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no progress for %0d cycles, %0d results owed",
               quiet_cycles, expected_matches.size());
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Matching stream at the reset format, with extreme field values
  task automatic test_directed_match();
    logic [7:0] seq [27] = '{
      8'h09, 8'h04, 8'hFF, 8'hFF, 8'h01, 8'h01, 8'h02, 8'h00, 8'h00,
      8'h0B, 8'h24, 8'h02, 8'h01, 8'h01, 8'h02, 8'h10, 8'h01, 8'h80, 8'hBB, 8'h00,
      8'h07, 8'h05, 8'hFF, 8'hFD, 8'hFF, 8'hFF, 8'h00};
    set_bytes.delete();
    foreach (seq[i]) set_bytes.push_back(seq[i]);
    send_set();
  endtask

  // Length below two stops parsing; the remaining bytes are ignored
  task automatic test_short_length();
    set_bytes = '{8'h01, LEN_INTERFACE, KIND_INTERFACE};
    send_set();
  endtask

  task automatic test_random_sets(input int n_bytes);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      build_set();
      send_set();
    end
  endtask

  task automatic test_random_config(input int n_bytes);
    logic [23:0] rate;
    case ($urandom_range(0, 3))
      0:       rate = 24'd44100;
      1:       rate = 24'd48000;
      2:       rate = 24'd96000;
      default: rate = 24'($urandom);
    endcase
    drain();
    set_wanted(rate, 8'($urandom_range(1, 8)), 8'($urandom_range(1, 4)),
               8'($urandom_range(8, 32)));
    test_random_sets(n_bytes);
  endtask

  task automatic test_config_extremes(input int n_bytes);
    drain();
    set_wanted(24'd0, 8'd0, 8'd0, 8'd0);
    test_random_sets(n_bytes);
    drain();
    set_wanted(24'hFFFFFF, 8'hFF, 8'hFF, 8'hFF);
    test_random_sets(n_bytes);
  endtask

  // Hold the result side off while tiny sets keep arriving, so the input stalls
  task automatic test_backpressure(input int n_sets);
    fork
      begin
        hold_results = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_results = 1'b0;
      end
    join_none
    idle_enabled = 1'b0;
    repeat (n_sets) begin
      case ($urandom_range(0, 3))
        0:       set_bytes = '{8'h00};
        1:       set_bytes = '{8'h01};
        2:       set_bytes = '{8'($urandom), 8'($urandom)};
        default: build_set();
      endcase
      send_set();
    end
    idle_enabled = 1'b1;
    drain();
    wait (!hold_results);
  endtask

  initial begin
    want.rate = RATE_RESET;
    want.channels = CHANNELS_RESET;
    want.subframe = SUBFRAME_RESET;
    want.bits = BITS_RESET;
    clear_scan();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_match();
    test_short_length();
    test_random_sets(200);
    test_random_config(350);
    test_config_extremes(200);
    test_backpressure(12);
    test_random_config(250);
    // last stretch runs with no idling on either side
    drain();
    idle_enabled = 1'b0;
    test_random_config(300);
    drain();

    $display("covered %0d descriptor sets in %0d bytes over %0d register settings",
             sets_checked, bytes_sent, cfg_phases + 1);
    $display("%0d sets held a matching stream; input stalled for %0d cycles",
             matches_seen, stalled_cycles);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d failures", fail_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== usb_audio_stream_descriptor_scan.f =====
src/uadsc_pkg.sv
src/uadsc_fifo.sv
src/uadsc_front.sv
src/uadsc_back.sv
src/usb_audio_stream_descriptor_scan.sv
sim/usb_audio_stream_descriptor_scan_tb.sv
